### design/v3alu_pkg.sv
package v3alu_pkg;

    // Operation codes.
    localparam logic [3:0] MODE_ADD    = 4'd0;
    localparam logic [3:0] MODE_SUB    = 4'd1;
    localparam logic [3:0] MODE_SCALE  = 4'd2;
    localparam logic [3:0] MODE_MUL3   = 4'd3;
    localparam logic [3:0] MODE_CROSS  = 4'd4;
    localparam logic [3:0] MODE_DOT    = 4'd5;
    localparam logic [3:0] MODE_LENSQ  = 4'd6;
    localparam logic [3:0] MODE_NEGATE = 4'd7;
    localparam logic [3:0] MODE_MIX    = 4'd8;
    localparam logic [3:0] MODE_EQUALS = 4'd9;

    localparam int Q_SHIFT = 16;
    // 1.0 in Q16.16, widened to the mix operand width.
    localparam logic signed [32:0] Q_ONE = 33'sd65536;

    // A 32 x 33 bit product is 65 bits; after the Q shift 49 bits remain.
    localparam int W_PROD = 65;
    localparam int W_Q    = W_PROD - Q_SHIFT;
    // Room for the sum of three shifted products.
    localparam int W_SUM  = W_Q + 3;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scalar;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic               equal_flag;
        logic               saturated;
    } t_res;

endpackage

### design/v3alu_qmul.sv
module v3alu_qmul
    import v3alu_pkg::*;
(
    input  logic                  i_clk,
    input  logic signed [31:0]    i_a,
    input  logic signed [32:0]    i_b,
    output logic signed [W_Q-1:0] o_q
);

    logic signed [W_PROD-1:0] w_prod;
    logic signed [W_Q-1:0]    r_q;

    assign w_prod = i_a * i_b;

    // Dropping the low bits of a two's complement product rounds toward
    // minus infinity.
    always_ff @(posedge i_clk) begin
        r_q <= w_prod[W_PROD-1:Q_SHIFT];
    end

    assign o_q = r_q;

endmodule

### design/vec3_fixed_point_alu.sv
// Three-component vector ALU on signed Q16.16 values.
//
// A request is taken at every rising edge where start is high and busy is
// low. busy is always low, so a new request may be issued in every cycle.
// The request carries the operation code, vectors A and B and a scalar.
//
// Each request yields exactly one result, shown on o_res for one cycle
// with o_done high. The request passes the first stage, registered in the
// multipliers and r_v1, and then the second, registered in r_res and r_done.
// The first stage forms up to six 32 x 33 bit products, the second
// combines them and clips each component to the signed 32-bit range.
// Throughput is one request per clock.
//
// The receiver cannot stall; o_done is a strobe and o_res is reloaded at
// every rising edge. The block holds no state besides the pipeline.
// Synchronous reset (i_rst_n low) drops any request in flight.
module vec3_fixed_point_alu
    import v3alu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    localparam logic signed [W_SUM-1:0] S32_MAX = W_SUM'(64'sd2147483647);
    localparam logic signed [W_SUM-1:0] S32_MIN = W_SUM'(-64'sd2147483648);

    logic               w_take;
    logic signed [32:0] w_s;
    logic signed [32:0] w_oms;
    logic signed [31:0] w_opa [6];
    logic signed [32:0] w_opb [6];
    logic signed [W_Q-1:0] w_q [6];

    logic signed [32:0] n_lin [3];
    logic signed [32:0] r_lin [3];
    logic [3:0]         r_mode;
    logic               r_eq;
    logic               r_v1;

    logic signed [W_SUM-1:0] w_r [3];
    logic [2:0]              w_clip;
    logic signed [31:0]      w_out [3];
    t_res                    r_res;
    logic                    r_done;

    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    assign w_s   = 33'(i_req.scalar);
    assign w_oms = Q_ONE - w_s;

    // Operand routing for the six product slots. Slots 0..2 serve every
    // multiplying mode; slots 3..5 hold the second term of cross and mix.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_opa[i] = '0;
            w_opb[i] = '0;
        end
        case (i_req.mode)
            MODE_SCALE, MODE_MIX: begin
                w_opa[0] = i_req.a_x;  w_opb[0] = w_s;
                w_opa[1] = i_req.a_y;  w_opb[1] = w_s;
                w_opa[2] = i_req.a_z;  w_opb[2] = w_s;
                w_opa[3] = i_req.b_x;  w_opb[3] = w_oms;
                w_opa[4] = i_req.b_y;  w_opb[4] = w_oms;
                w_opa[5] = i_req.b_z;  w_opb[5] = w_oms;
            end
            MODE_MUL3, MODE_DOT: begin
                w_opa[0] = i_req.a_x;  w_opb[0] = 33'(i_req.b_x);
                w_opa[1] = i_req.a_y;  w_opb[1] = 33'(i_req.b_y);
                w_opa[2] = i_req.a_z;  w_opb[2] = 33'(i_req.b_z);
            end
            MODE_LENSQ: begin
                w_opa[0] = i_req.a_x;  w_opb[0] = 33'(i_req.a_x);
                w_opa[1] = i_req.a_y;  w_opb[1] = 33'(i_req.a_y);
                w_opa[2] = i_req.a_z;  w_opb[2] = 33'(i_req.a_z);
            end
            MODE_CROSS: begin
                w_opa[0] = i_req.a_y;  w_opb[0] = 33'(i_req.b_z);
                w_opa[1] = i_req.a_z;  w_opb[1] = 33'(i_req.b_x);
                w_opa[2] = i_req.a_x;  w_opb[2] = 33'(i_req.b_y);
                w_opa[3] = i_req.a_z;  w_opb[3] = 33'(i_req.b_y);
                w_opa[4] = i_req.a_x;  w_opb[4] = 33'(i_req.b_z);
                w_opa[5] = i_req.a_y;  w_opb[5] = 33'(i_req.b_x);
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < 6; g++) begin : g_mul
        v3alu_qmul u_qmul (
            .i_clk (i_clk),
            .i_a   (w_opa[g]),
            .i_b   (w_opb[g]),
            .o_q   (w_q[g])
        );
    end

    // Add, subtract and negate need no product; they run beside the
    // multipliers in the first stage.
    always_comb begin
        logic signed [32:0] a [3];
        logic signed [32:0] b [3];
        a[0] = 33'(i_req.a_x);  b[0] = 33'(i_req.b_x);
        a[1] = 33'(i_req.a_y);  b[1] = 33'(i_req.b_y);
        a[2] = 33'(i_req.a_z);  b[2] = 33'(i_req.b_z);
        for (int i = 0; i < 3; i++) begin
            case (i_req.mode)
                MODE_ADD:    n_lin[i] = a[i] + b[i];
                MODE_SUB:    n_lin[i] = a[i] - b[i];
                MODE_NEGATE: n_lin[i] = -a[i];
                default:     n_lin[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= i_req.mode;
        r_eq   <= (i_req.mode == MODE_EQUALS) && (i_req.a_x == i_req.b_x)
                  && (i_req.a_y == i_req.b_y) && (i_req.a_z == i_req.b_z);
        for (int i = 0; i < 3; i++) begin
            r_lin[i] <= n_lin[i];
        end
    end

    // Second stage: combine the shifted products, or pass on the add, subtract and negate results.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_r[i] = '0;
        end
        case (r_mode)
            MODE_ADD, MODE_SUB, MODE_NEGATE: begin
                for (int i = 0; i < 3; i++) begin
                    w_r[i] = W_SUM'(r_lin[i]);
                end
            end
            MODE_SCALE, MODE_MUL3: begin
                for (int i = 0; i < 3; i++) begin
                    w_r[i] = W_SUM'(w_q[i]);
                end
            end
            MODE_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    w_r[i] = W_SUM'(w_q[i]) - W_SUM'(w_q[i+3]);
                end
            end
            MODE_MIX: begin
                for (int i = 0; i < 3; i++) begin
                    w_r[i] = W_SUM'(w_q[i]) + W_SUM'(w_q[i+3]);
                end
            end
            MODE_DOT, MODE_LENSQ: begin
                w_r[0] = W_SUM'(w_q[0]) + W_SUM'(w_q[1]) + W_SUM'(w_q[2]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_r[i] > S32_MAX) begin
                w_clip[i] = 1'b1;
                w_out[i]  = S32_MAX[31:0];
            end else if (w_r[i] < S32_MIN) begin
                w_clip[i] = 1'b1;
                w_out[i]  = S32_MIN[31:0];
            end else begin
                w_clip[i] = 1'b0;
                w_out[i]  = w_r[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.result_x   <= w_out[0];
        r_res.result_y   <= w_out[1];
        r_res.result_z   <= w_out[2];
        r_res.equal_flag <= r_eq;
        r_res.saturated  <= |w_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= w_take;
            r_done <= r_v1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### tb/vec3_fixed_point_alu_tb.sv
`timescale 1ns / 100ps

module vec3_fixed_point_alu_tb;
    import v3alu_pkg::*;

    localparam logic [3:0]  MODE_TOP    = 4'hF;
    localparam logic [31:0] Q_MAX_RAW   = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN_RAW   = 32'h8000_0000;
    localparam logic [31:0] Q_UNIT      = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_UNIT  = 32'hffff_0000;
    localparam longint      LIM_HI      = 64'sd2147483647;
    localparam longint      LIM_LO      = -64'sd2147483648;
    localparam int          N_RANDOM    = 1900;
    localparam int          N_CALM_TAIL = 300;

    // Predicts each result of the vector ALU and checks the results in order.
    class vec3_alu_checker;
        t_res awaited_results[$];
        int   errors;

        // Q16.16 product; the arithmetic shift rounds toward minus infinity.
        static function longint qmul(longint a, longint b);
            return (a * b) >>> Q_SHIFT;
        endfunction

        static function logic [31:0] clip32(input longint v, inout logic sat);
            if (v > LIM_HI) begin
                sat = 1'b1;
                return Q_MAX_RAW;
            end
            if (v < LIM_LO) begin
                sat = 1'b1;
                return Q_MIN_RAW;
            end
            return v[31:0];
        endfunction

        function void note_request(t_req r);
            longint ax, ay, az, bx, by, bz, s, one_minus_s;
            longint rx, ry, rz;
            logic   sat;
            t_res   e;
            ax = $signed(r.a_x);
            ay = $signed(r.a_y);
            az = $signed(r.a_z);
            bx = $signed(r.b_x);
            by = $signed(r.b_y);
            bz = $signed(r.b_z);
            s  = $signed(r.scalar);
            one_minus_s = longint'(Q_ONE) - s;
            rx = 0;
            ry = 0;
            rz = 0;
            sat = 1'b0;
            e = '0;
            case (r.mode)
                MODE_ADD: begin
                    rx = ax + bx;
                    ry = ay + by;
                    rz = az + bz;
                end
                MODE_SUB: begin
                    rx = ax - bx;
                    ry = ay - by;
                    rz = az - bz;
                end
                MODE_SCALE: begin
                    rx = qmul(ax, s);
                    ry = qmul(ay, s);
                    rz = qmul(az, s);
                end
                MODE_MUL3: begin
                    rx = qmul(ax, bx);
                    ry = qmul(ay, by);
                    rz = qmul(az, bz);
                end
                MODE_CROSS: begin
                    rx = qmul(ay, bz) - qmul(az, by);
                    ry = qmul(az, bx) - qmul(ax, bz);
                    rz = qmul(ax, by) - qmul(ay, bx);
                end
                MODE_DOT: begin
                    rx = qmul(ax, bx) + qmul(ay, by) + qmul(az, bz);
                end
                MODE_LENSQ: begin
                    rx = qmul(ax, ax) + qmul(ay, ay) + qmul(az, az);
                end
                MODE_NEGATE: begin
                    rx = -ax;
                    ry = -ay;
                    rz = -az;
                end
                MODE_MIX: begin
                    rx = qmul(ax, s) + qmul(bx, one_minus_s);
                    ry = qmul(ay, s) + qmul(by, one_minus_s);
                    rz = qmul(az, s) + qmul(bz, one_minus_s);
                end
                MODE_EQUALS: begin
                    e.equal_flag = (ax == bx) && (ay == by) && (az == bz);
                end
                default: begin
                end
            endcase
            e.result_x  = clip32(rx, sat);
            e.result_y  = clip32(ry, sat);
            e.result_z  = clip32(rz, sat);
            e.saturated = sat;
            awaited_results.push_back(e);
        endfunction

        function void flag_mismatch(string what, longint want, longint seen);
            errors++;
            if (errors <= 10) begin
                $display("mismatch in %s: expected %0d, got %0d", what, want, seen);
            end
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %p arrived with no request outstanding", got);
                end
                return;
            end
            e = awaited_results.pop_front();
            if (got.result_x !== e.result_x) begin
                flag_mismatch("result_x", $signed(e.result_x), $signed(got.result_x));
            end
            if (got.result_y !== e.result_y) begin
                flag_mismatch("result_y", $signed(e.result_y), $signed(got.result_y));
            end
            if (got.result_z !== e.result_z) begin
                flag_mismatch("result_z", $signed(e.result_z), $signed(got.result_z));
            end
            if (got.equal_flag !== e.equal_flag) begin
                flag_mismatch("equal_flag", e.equal_flag, got.equal_flag);
            end
            if (got.saturated !== e.saturated) begin
                flag_mismatch("saturated", e.saturated, got.saturated);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_done;
    t_req i_req;
    t_res o_res;

    vec3_alu_checker board = new();

    vec3_fixed_point_alu u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("vec3_fixed_point_alu_tb: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            board.note_request(i_req);
        end
        if (i_rst_n && o_done) begin
            board.check_result(o_res);
        end
    end

    function automatic t_req make_req(logic [3:0] m, logic [31:0] ax, logic [31:0] ay,
                                      logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                      logic [31:0] bz, logic [31:0] sc);
        t_req r;
        r.mode   = m;
        r.a_x    = ax;
        r.a_y    = ay;
        r.a_z    = az;
        r.b_x    = bx;
        r.b_y    = by;
        r.b_z    = bz;
        r.scalar = sc;
        return r;
    endfunction

    // Mostly full-range words, with a share of extremes and of small magnitudes.
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 6))
                    0: return Q_MIN_RAW;
                    1: return Q_MAX_RAW;
                    2: return Q_UNIT;
                    3: return Q_NEG_UNIT;
                    4: return 32'h0000_0001;
                    5: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req rand_request();
        t_req        r;
        logic [31:0] flip;
        if ($urandom_range(0, 19) == 0) begin
            r.mode = 4'($urandom_range(MODE_EQUALS + 4'd1, MODE_TOP));
        end else begin
            r.mode = 4'($urandom_range(MODE_ADD, MODE_EQUALS));
        end
        r.a_x    = rand_q();
        r.a_y    = rand_q();
        r.a_z    = rand_q();
        r.b_x    = rand_q();
        r.b_y    = rand_q();
        r.b_z    = rand_q();
        r.scalar = rand_q();
        // Blend ratios between 0.0 and 1.0 are the usual use of scale and mix.
        if ((r.mode == MODE_MIX || r.mode == MODE_SCALE) && $urandom_range(0, 1)) begin
            r.scalar = $urandom_range(0, Q_UNIT);
        end
        // Equal vectors are rare by chance, so build them, sometimes off by one bit.
        if (r.mode == MODE_EQUALS && $urandom_range(0, 1)) begin
            r.b_x = r.a_x;
            r.b_y = r.a_y;
            r.b_z = r.a_z;
            flip = 32'h1 << $urandom_range(0, 31);
            case ($urandom_range(0, 5))
                0: r.b_x = r.b_x ^ flip;
                1: r.b_y = r.b_y ^ flip;
                2: r.b_z = r.b_z ^ flip;
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    task automatic send_request(t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // The queue is sampled away from the rising edge, where the monitor may not
    // yet have noted the last request.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (board.awaited_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(make_req(MODE_ADD, Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW,
                              Q_MAX_RAW, Q_UNIT, Q_MIN_RAW, Q_MIN_RAW));
        send_request(make_req(MODE_ADD, Q_MIN_RAW, Q_MIN_RAW, 32'h0001_8000,
                              Q_MIN_RAW, Q_MAX_RAW, 32'h0002_4000, Q_MAX_RAW));
        send_request(make_req(MODE_SUB, Q_MIN_RAW, Q_MAX_RAW, Q_UNIT,
                              Q_MAX_RAW, Q_MIN_RAW, Q_NEG_UNIT, 32'h0));
        send_request(make_req(MODE_SUB, 32'h0003_0000, 32'hffff_ffff, 32'h0,
                              32'h0001_0000, 32'h0000_0001, 32'h0, Q_UNIT));
        send_request(make_req(MODE_SCALE, Q_MAX_RAW, Q_MIN_RAW, Q_UNIT,
                              32'h0, 32'h0, 32'h0, Q_MAX_RAW));
        // A tiny negative product must round down, not toward zero.
        send_request(make_req(MODE_SCALE, 32'hffff_ffff, 32'h0000_0001, Q_NEG_UNIT,
                              Q_MAX_RAW, Q_MIN_RAW, Q_MAX_RAW, 32'h0000_0001));
        send_request(make_req(MODE_MUL3, Q_MIN_RAW, Q_MAX_RAW, Q_MIN_RAW,
                              Q_MIN_RAW, Q_MIN_RAW, Q_MAX_RAW, 32'h0));
        send_request(make_req(MODE_MUL3, Q_UNIT, 32'h0002_8000, 32'hffff_ffff,
                              Q_UNIT, Q_NEG_UNIT, 32'h0000_0001, 32'h0));
        send_request(make_req(MODE_CROSS, Q_MAX_RAW, Q_MIN_RAW, Q_MAX_RAW,
                              Q_MIN_RAW, Q_MAX_RAW, Q_MIN_RAW, 32'h0));
        send_request(make_req(MODE_CROSS, Q_UNIT, 32'h0, 32'h0,
                              32'h0, Q_UNIT, 32'h0, 32'h0));
        send_request(make_req(MODE_DOT, Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW,
                              Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW, 32'h0));
        send_request(make_req(MODE_DOT, 32'h0002_0000, Q_NEG_UNIT, 32'h0000_8000,
                              32'h0003_0000, 32'h0004_0000, 32'hffff_ffff, 32'h0));
        send_request(make_req(MODE_LENSQ, Q_MIN_RAW, Q_MIN_RAW, Q_MIN_RAW,
                              32'h0, 32'h0, 32'h0, 32'h0));
        send_request(make_req(MODE_LENSQ, 32'h0000_0001, Q_NEG_UNIT, 32'h0001_8000,
                              Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW));
        // Negating the most negative value overflows and must saturate.
        send_request(make_req(MODE_NEGATE, Q_MIN_RAW, Q_MAX_RAW, 32'h0,
                              32'h0, 32'h0, 32'h0, 32'h0));
        send_request(make_req(MODE_NEGATE, Q_UNIT, 32'hffff_ffff, Q_MIN_RAW,
                              Q_MIN_RAW, Q_MIN_RAW, Q_MIN_RAW, Q_MIN_RAW));
        send_request(make_req(MODE_MIX, Q_MAX_RAW, Q_MIN_RAW, Q_UNIT,
                              Q_MIN_RAW, Q_MAX_RAW, 32'h0003_0000, 32'h0));
        send_request(make_req(MODE_MIX, Q_MAX_RAW, Q_MIN_RAW, Q_UNIT,
                              Q_MIN_RAW, Q_MAX_RAW, 32'h0003_0000, Q_UNIT));
        send_request(make_req(MODE_MIX, Q_MAX_RAW, Q_MIN_RAW, Q_MIN_RAW,
                              Q_MIN_RAW, Q_MAX_RAW, Q_MAX_RAW, Q_MIN_RAW));
        send_request(make_req(MODE_MIX, Q_MIN_RAW, Q_MAX_RAW, Q_UNIT,
                              Q_MIN_RAW, Q_MAX_RAW, Q_NEG_UNIT, Q_MAX_RAW));
        send_request(make_req(MODE_EQUALS, Q_MIN_RAW, Q_MAX_RAW, 32'h1234_5678,
                              Q_MIN_RAW, Q_MAX_RAW, 32'h1234_5678, Q_MAX_RAW));
        send_request(make_req(MODE_EQUALS, Q_MIN_RAW, Q_MAX_RAW, 32'h1234_5678,
                              Q_MIN_RAW, Q_MAX_RAW, 32'h1234_5679, Q_MAX_RAW));
        // Unused codes still produce one all-zero result.
        send_request(make_req(MODE_EQUALS + 4'd1, Q_MIN_RAW, Q_MIN_RAW, Q_MIN_RAW,
                              Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW));
        send_request(make_req(MODE_TOP, Q_MAX_RAW, Q_UNIT, Q_MIN_RAW,
                              Q_MAX_RAW, Q_MAX_RAW, Q_MAX_RAW, Q_MIN_RAW));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                wait_drained();
            end
            if (n < N_RANDOM - N_CALM_TAIL && $urandom_range(0, 7) == 0) begin
                idle_cycles($urandom_range(1, 19));
            end
            send_request(rand_request());
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("vec3_fixed_point_alu_tb: clean");
        end else begin
            $display("vec3_fixed_point_alu_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/v3alu_pkg.sv
design/v3alu_qmul.sv
design/vec3_fixed_point_alu.sv
tb/vec3_fixed_point_alu_tb.sv
